FILE: rtl/core/vle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vle_pkg: shared types and constants for the varint encoder
// Group size, stop mark and length limits of the 7-bit byte code.
// ----------------------------------------------------------------------------
package vle_pkg;

	localparam int unsigned VALUE_W   = 64;
	localparam int unsigned GROUP_W   = 7;
	localparam int unsigned MAX_BYTES = 10;
	localparam int unsigned CNT_W     = 4;

	typedef logic [VALUE_W-1:0] value_t;
	typedef logic [GROUP_W-1:0] group_t;
	typedef logic [CNT_W-1:0]   count_t;
	typedef logic [7:0]         code_t;

	localparam code_t  STOP_MARK  = 8'b1000_0000;
	localparam group_t GROUP_MASK = 7'b111_1111;
	localparam count_t LEN_MAX    = count_t'(MAX_BYTES);

endpackage : vle_pkg
`default_nettype wire

FILE: rtl/core/varint64_encoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// varint64_encoder: unsigned 64-bit value to 7-bit-group byte code
// Shifts out one 7-bit digit per cycle unless stalled, lowest group first.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, value): one 64-bit unsigned item.
//   Output channel (out_valid/out_ready): one item per encoded byte, carrying
//   code_byte, byte_index, total_length and is_last. 1 to 10 bytes per value;
//   bit 7 of code_byte is set only on the final byte (zero gives 0x80).
// The accepted value is loaded into the digit shifter; its first byte then
//   moves into the output register and shows on out_valid.
// Throughput: with out_ready held high, a value is loaded, then sent at
//   one byte per cycle. The rate is set by the 7-bit digit shift register,
//   which moves one group per cycle into the output register.
// in_ready is high only while no encoding is in flight; the next value may be
//   accepted while the final byte still waits in the output register.
// Receiver stall: the output register holds its byte and the shifter waits;
//   nothing is lost or repeated.
// Reset (arst_n low): in-flight encoding and the output register are dropped;
//   the block comes up ready with out_valid low.
// ----------------------------------------------------------------------------
module varint64_encoder
	import vle_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [63:0] value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       code_byte,
	output logic [3:0]       byte_index,
	output logic [3:0]       total_length,
	output logic             is_last
);

	// digit shifter and per-encoding counters
	value_t shift_q;
	count_t len_q;
	count_t left_q;
	count_t idx_q;
	logic   busy_q;

	// output register
	logic   out_valid_q;
	code_t  code_q;
	count_t oidx_q;
	count_t olen_q;
	logic   olast_q;

	logic   in_fire;
	logic   emit;
	logic   last_byte;
	count_t load_len;

	// Length: one past the highest nonzero group; group 9 is bit 63 alone.
	always_comb begin
		load_len = count_t'(1);
		for (int g = 1; g < int'(MAX_BYTES) - 1; g++) begin
			if (|value[g*GROUP_W +: GROUP_W])
				load_len = count_t'(g + 1);
		end
		if (value[VALUE_W-1])
			load_len = LEN_MAX;
	end

	assign in_ready  = !busy_q;
	assign in_fire   = in_valid && in_ready;
	// move the next digit whenever the output register is free or draining
	assign emit      = busy_q && (!out_valid_q || out_ready);
	assign last_byte = (left_q == count_t'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			left_q      <= '0;
		end else begin
			if (in_fire) begin
				busy_q <= 1'b1;
				left_q <= load_len;
			end else if (emit) begin
				left_q <= left_q - count_t'(1);
				if (last_byte)
					busy_q <= 1'b0;
			end
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (in_fire) begin
			shift_q <= value;
			len_q   <= load_len;
			idx_q   <= '0;
		end else if (emit) begin
			shift_q <= shift_q >> GROUP_W;
			idx_q   <= idx_q + count_t'(1);
		end
		if (emit) begin
			code_q  <= {last_byte, shift_q[GROUP_W-1:0] & GROUP_MASK};
			oidx_q  <= idx_q;
			olen_q  <= len_q;
			olast_q <= last_byte;
		end
	end

	assign out_valid    = out_valid_q;
	assign code_byte    = code_q;
	assign byte_index   = oidx_q;
	assign total_length = olen_q;
	assign is_last      = olast_q;

endmodule : varint64_encoder
`default_nettype wire

FILE: rtl/core/vle_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vle_checker: port-level checks for the varint encoder
// Watches both channels and the byte fields; bound to varint64_encoder.
// ----------------------------------------------------------------------------
module vle_checker
	import vle_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic [63:0] value,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [7:0]  code_byte,
	input wire logic [3:0]  byte_index,
	input wire logic [3:0]  total_length,
	input wire logic        is_last
);

	// stalled output item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(code_byte) &&
		$stable(byte_index) && $stable(total_length) && $stable(is_last))
		else $error("output item changed while stalled");

	// stop mark and last flag agree with position and length
	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (code_byte[7] == is_last) &&
		(is_last == (byte_index == total_length - 4'd1)))
		else $error("stop mark inconsistent with position");

	// length in range, index below it
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (total_length != 4'd0) && (total_length <= LEN_MAX) &&
		(byte_index < total_length))
		else $error("length or index out of range");

	// a taken non-final byte is followed at once by the next one
	a_next_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !is_last |=> out_valid &&
		(byte_index == $past(byte_index) + 4'd1))
		else $error("gap or skip within an encoding");

	// a new value is only taken once the final byte is in the output stage
	a_ready_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && out_valid |-> is_last)
		else $error("input ready mid-encoding");

endmodule : vle_checker

bind varint64_encoder vle_checker u_vle_checker (.*);
`default_nettype wire
